// ----- sv/tlcd_pkg.sv -----
// Shared types, codes and the init command table for the character LCD nibble writer.
package tlcd_pkg;

  typedef enum logic [1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_TEXT  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [2:0] CFG_ROW0 = 3'd0;
  localparam logic [2:0] CFG_ROW1 = 3'd1;
  localparam logic [2:0] CFG_ROW2 = 3'd2;
  localparam logic [2:0] CFG_ROW3 = 3'd3;
  localparam logic [2:0] CFG_COLS = 3'd4;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] CMD_LONG_LIM  = 8'h04;
  localparam logic [3:0] INIT_LAST_NIB = 4'd11;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       long_wait;
    logic       last;
  } out_item_t;

  typedef enum logic {
    OP_INIT  = 1'b0,
    OP_BYTES = 1'b1
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic       two;
    logic       b0_rs;
    logic [7:0] b0_val;
    logic [7:0] b1_val;
  } job_t;

  typedef struct packed {
    logic [6:0] row0;
    logic [6:0] row1;
    logic [6:0] row2;
    logic [6:0] row3;
    logic [5:0] cols;
  } cfg_regs_t;

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h33;
      3'd1:    v = 8'h32;
      3'd2:    v = 8'h20 | 8'h08;
      3'd3:    v = 8'h08 | 8'h04;
      3'd4:    v = 8'h04 | 8'h02;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/tlcd_front.sv -----
// Front end: configuration registers, display position tracking and job classification.
module tlcd_front #(
  parameter int ROWS        = 4,
  parameter int MAX_COLUMNS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlcd_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output tlcd_pkg::job_t    q_data
);
  import tlcd_pkg::*;

  localparam int RW = $clog2(ROWS + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  cfg_regs_t     cfg_r;
  logic          ready_r, ready_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          accept;
  logic          job_valid;
  logic [2:0]    row_inc;
  logic [6:0]    col_inc;
  logic [6:0]    lim;
  logic          row_ok;
  logic [7:0]    next_addr_cmd;

  function automatic logic [6:0] row_addr(input cfg_regs_t c, input logic [2:0] r);
    logic [6:0] a;
    unique case (r)
      3'd0:    a = c.row0;
      3'd1:    a = c.row1;
      3'd2:    a = c.row2;
      default: a = c.row3;
    endcase
    return a;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && job_valid;

  assign row_inc       = 3'(row_r) + 3'd1;
  assign row_ok        = row_inc < 3'(ROWS);
  assign next_addr_cmd = CMD_SET_ADDR | {1'b0, row_addr(cfg_r, row_inc)};
  assign col_inc       = 7'(col_r) + 7'd1;

  always_comb begin
    if (cfg_r.cols == 6'd0) begin
      lim = 7'd1;
    end else if (7'(cfg_r.cols) > 7'(MAX_COLUMNS)) begin
      lim = 7'(MAX_COLUMNS);
    end else begin
      lim = 7'(cfg_r.cols);
    end
  end

  always_comb begin
    ready_nxt = ready_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    job_valid = 1'b0;
    q_data    = '{op: OP_BYTES, two: 1'b0, b0_rs: 1'b0, b0_val: 8'h00, b1_val: 8'h00};
    unique case (func_t'(in_item.func))
      FUNC_INIT: begin
        job_valid = 1'b1;
        q_data.op = OP_INIT;
        ready_nxt = 1'b1;
        row_nxt   = RW'(ROWS);
        col_nxt   = '0;
      end
      FUNC_FRAME: begin
        if (ready_r) begin
          job_valid     = 1'b1;
          q_data.two    = 1'b1;
          q_data.b0_val = CMD_CLEAR;
          q_data.b1_val = CMD_SET_ADDR | {1'b0, cfg_r.row0};
          row_nxt       = '0;
          col_nxt       = '0;
        end
      end
      FUNC_TEXT: begin
        if (ready_r && (3'(row_r) < 3'(ROWS))) begin
          if (in_item.text_byte == CHAR_NEWLINE) begin
            col_nxt = '0;
            if (row_ok) begin
              job_valid     = 1'b1;
              q_data.b0_val = next_addr_cmd;
              row_nxt       = RW'(row_inc);
            end else begin
              row_nxt = RW'(ROWS);
            end
          end else begin
            job_valid     = 1'b1;
            q_data.b0_rs  = 1'b1;
            q_data.b0_val = in_item.text_byte;
            col_nxt       = CW'(col_inc);
            if (col_inc >= lim) begin
              col_nxt = '0;
              if (row_ok) begin
                q_data.two    = 1'b1;
                q_data.b1_val = next_addr_cmd;
                row_nxt       = RW'(row_inc);
              end else begin
                row_nxt = RW'(ROWS);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
      row_r   <= RW'(ROWS);
      col_r   <= '0;
      cfg_r   <= '{row0: 7'd0, row1: 7'd64, row2: 7'd20, row3: 7'd84, cols: 6'd20};
    end else begin
      if (accept) begin
        ready_r <= ready_nxt;
        row_r   <= row_nxt;
        col_r   <= col_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW0: cfg_r.row0 <= cfg_data;
          CFG_ROW1: cfg_r.row1 <= cfg_data;
          CFG_ROW2: cfg_r.row2 <= cfg_data;
          CFG_ROW3: cfg_r.row3 <= cfg_data;
          CFG_COLS: cfg_r.cols <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- sv/tlcd_fifo.sv -----
// Short job queue between the front end and the nibble sequencer.
module tlcd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlcd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tlcd_pkg::job_t head
);
  import tlcd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;

  assign full  = count_r == (AW + 1)'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tlcd_back.sv -----
// Back end: splits each queued job into nibble transfers behind an output register.
module tlcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tlcd_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tlcd_pkg::out_item_t out_item
);
  import tlcd_pkg::*;

  logic [3:0] nib_r, nib_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       load;
  logic [3:0] last_nib;
  logic       byte_rs;
  logic [7:0] byte_val;
  logic       is_last;

  assign load     = !q_empty && (!out_valid_r || out_ready);
  assign last_nib = (q_head.op == OP_INIT) ? INIT_LAST_NIB : (q_head.two ? 4'd3 : 4'd1);
  assign is_last  = nib_r == last_nib;
  assign q_pop    = load && is_last;

  always_comb begin
    if (q_head.op == OP_INIT) begin
      byte_rs  = 1'b0;
      byte_val = init_byte(nib_r[3:1]);
    end else if (nib_r[1]) begin
      byte_rs  = 1'b0;
      byte_val = q_head.b1_val;
    end else begin
      byte_rs  = q_head.b0_rs;
      byte_val = q_head.b0_val;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    nib_nxt       = nib_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.reg_select = byte_rs;
      out_item_nxt.nibble    = nib_r[0] ? byte_val[3:0] : byte_val[7:4];
      out_item_nxt.long_wait = nib_r[0] && !byte_rs && (byte_val < CMD_LONG_LIM);
      out_item_nxt.last      = is_last;
      nib_nxt                = is_last ? 4'd0 : nib_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      nib_r       <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      nib_r       <= nib_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sv/text_to_char_lcd_nibble_writer.sv -----
// Top level of the 4-bit character LCD nibble writer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item (func, text_byte)
//   out      output     out_valid/out_ready  out_item (reg_select, nibble, long_wait, last)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// The front end takes one item per cycle while the job queue has room.
// The back end sends one nibble per cycle while a job is queued: a text byte gives 2 or 4
// nibbles, begin-frame 4, init 12, and ignored items none; the output port sets the rate.
// Reset leaves the display not initialized and the configuration at its defaults.
// A stalled output holds its nibble, and the queue lets input keep flowing until it fills.
module text_to_char_lcd_nibble_writer #(
  parameter int ROWS        = 4,
  parameter int MAX_COLUMNS = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlcd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tlcd_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [6:0]          cfg_data
);
  import tlcd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_data, q_head;

  tlcd_front #(
    .ROWS        (ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  tlcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tlcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
